FILE: design/srm_pkg.sv
package srm_pkg;

  localparam int MAX_WINDOW_SAMPLES = 16777216;
  localparam int SAMPLE_WIDTH       = 16;
  localparam int TIME_WIDTH         = 32;

  // Configuration register indexes
  localparam logic [2:0] REG_EVENT_TIME   = 3'd0;
  localparam logic [2:0] REG_BAND         = 3'd1;
  localparam logic [2:0] REG_DWELL        = 3'd2;
  localparam logic [2:0] REG_LEVEL_BEFORE = 3'd3;
  localparam logic [2:0] REG_LEVEL_AFTER  = 3'd4;
  localparam logic [2:0] REG_STEP_PRESENT = 3'd5;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_ORDER    = 2'd2;

  localparam logic [1:0] SETTLE_DONE    = 2'd0;
  localparam logic [1:0] SETTLE_ALREADY = 2'd1;
  localparam logic [1:0] SETTLE_NONE    = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_START,
    ST_DIV,
    ST_SQRT,
    ST_RATIO,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;        // accumulate accepted request
    logic start_div;   // load divider and ratio units
    logic div_step;
    logic sqrt_step;
    logic ratio_step;
    logic load_out;    // capture result, clear window
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic ratio_done;
  } status_t;

endpackage

FILE: design/srm_datapath.sv
module srm_datapath
  import srm_pkg::*;
#(
  parameter int MaxSamples = MAX_WINDOW_SAMPLES,
  parameter int SampleW    = SAMPLE_WIDTH,
  parameter int TimeW      = TIME_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic [TimeW-1:0]          cfg_event,
  input  logic [SampleW-1:0]        cfg_band,
  input  logic [TimeW-1:0]          cfg_dwell,
  input  logic signed [SampleW-1:0] cfg_before,
  input  logic signed [SampleW-1:0] cfg_after,
  input  logic                      cfg_step,
  input  logic [TimeW-1:0]          in_time,
  input  logic signed [SampleW-1:0] in_ref,
  input  logic signed [SampleW-1:0] in_meas,
  output logic [1:0]                o_error,
  output logic [SampleW-1:0]        o_peak,
  output logic [SampleW-1:0]        o_rms,
  output logic [SampleW-1:0]        o_final,
  output logic [1:0]                o_settle,
  output logic [TimeW-1:0]          o_duration,
  output logic                      o_ov_valid,
  output logic [23:0]               o_ratio
);

  localparam int CntW = $clog2(MaxSamples + 1);
  localparam int SqW  = 2 * SampleW + CntW;
  localparam int ExW  = SampleW + 1;
  localparam int QW   = ExW + 16;
  localparam int SqIt = SampleW;
  localparam int DivCW = $clog2(SqW + 1);
  localparam int RatCW = $clog2(QW + 1);
  localparam int SqCW  = $clog2(SqIt + 1);

  logic                window_open, first_in_band, run_active, settled_flag, order_fault;
  logic [SampleW-1:0]  peak_abs, latest_abs;
  logic [SqW-1:0]      square_sum;
  logic [CntW-1:0]     window_count;
  logic [TimeW-1:0]    run_begin, settled_begin, previous_time;
  logic [ExW-1:0]      max_excursion;

  // Per-sample combinational terms
  logic signed [SampleW:0]   err;
  logic [SampleW-1:0]        abs_e;
  logic                      in_win, in_band, settle_now;
  logic [TimeW-1:0]          run_start;
  logic signed [SampleW+1:0] amp, exc;
  logic                      ov_ok;
  logic [2*SampleW-1:0]      sq;

  always_comb begin
    err   = (SampleW+1)'(in_meas) - (SampleW+1)'(in_ref);
    abs_e = err[SampleW] ? SampleW'(-err) : SampleW'(err);
    in_win = !(order_fault || in_time < previous_time) && in_time >= cfg_event;
    in_band = abs_e <= cfg_band;
    run_start = run_active ? run_begin : in_time;
    settle_now = in_band && ((in_time - run_start) >= cfg_dwell);
    amp = (SampleW+2)'(cfg_after) - (SampleW+2)'(cfg_before);
    ov_ok = cfg_step && (amp != '0);
    exc = (SampleW+2)'(in_meas) - (SampleW+2)'(cfg_after);
    if (amp[SampleW+1]) exc = -exc;
    sq = abs_e * abs_e;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      window_open <= 1'b0; first_in_band <= 1'b0; run_active <= 1'b0;
      settled_flag <= 1'b0; order_fault <= 1'b0; peak_abs <= '0;
      square_sum <= '0; window_count <= '0; latest_abs <= '0;
      run_begin <= '0; settled_begin <= '0; max_excursion <= '0;
      previous_time <= '0;
    end else if (cmd.take) begin
      previous_time <= in_time;
      if (in_time < previous_time) order_fault <= 1'b1;
      if (in_win) begin
        latest_abs <= abs_e;
        if (!window_open) begin
          window_open   <= 1'b1;
          first_in_band <= in_band;
        end
        if (abs_e > peak_abs) peak_abs <= abs_e;
        if (32'(window_count) < 32'(MaxSamples)) begin
          square_sum   <= square_sum + SqW'(sq);
          window_count <= window_count + 1'b1;
        end
        if (!settled_flag) begin
          if (in_band) begin
            run_active <= 1'b1;
            run_begin  <= run_start;
            if (settle_now) begin
              settled_flag  <= 1'b1;
              settled_begin <= run_start;
            end
          end else begin
            run_active <= 1'b0;
          end
        end
        if (ov_ok && !exc[SampleW+1] && exc != '0 && ExW'(exc) > max_excursion)
          max_excursion <= ExW'(exc);
      end
    end
  end

  // Restoring divider: square_sum / window_count, one bit per cycle
  logic [SqW-1:0]   div_q;
  logic [CntW:0]    div_r;
  logic [CntW-1:0]  div_d;
  logic [DivCW-1:0] div_cnt;
  logic [CntW:0]    div_trial;
  always_comb div_trial = {div_r[CntW-1:0], div_q[SqW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start_div) begin
      div_q   <= square_sum;
      div_r   <= '0;
      div_d   <= (window_count == '0) ? CntW'(1) : window_count;
      div_cnt <= DivCW'(SqW);
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
      if (div_trial >= {1'b0, div_d}) begin
        div_r <= div_trial - {1'b0, div_d};
        div_q <= {div_q[SqW-2:0], 1'b1};
      end else begin
        div_r <= div_trial;
        div_q <= {div_q[SqW-2:0], 1'b0};
      end
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle
  logic [2*SqIt-1:0] sq_x;
  logic [SqIt+1:0]   sq_rem;
  logic [SqIt-1:0]   sq_root;
  logic [SqCW-1:0]   sq_cnt;
  logic [SqIt+1:0]   sq_trial, sq_sub;
  always_comb begin
    sq_trial = {sq_rem[SqIt-1:0], sq_x[2*SqIt-1 -: 2]};
    sq_sub   = {sq_root, 2'b01};
  end

  // The mean square fits 2*SampleW bits, so the low quotient bits are the radicand.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (cmd.start_div) begin
      sq_cnt <= '0;
    end else if (cmd.div_step && div_cnt == DivCW'(1)) begin
      sq_cnt <= SqCW'(SqIt);
    end else if (cmd.sqrt_step && sq_cnt != '0) begin
      sq_cnt <= sq_cnt - 1'b1;
    end
    if (cmd.div_step && div_cnt == DivCW'(1)) begin
      sq_x    <= (2*SqIt)'({div_q[SqW-2:0], (div_trial >= {1'b0, div_d})});
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step && sq_cnt != '0) begin
      sq_x <= {sq_x[2*SqIt-3:0], 2'b00};
      if (sq_trial >= sq_sub) begin
        sq_rem  <= sq_trial - sq_sub;
        sq_root <= {sq_root[SqIt-2:0], 1'b1};
      end else begin
        sq_rem  <= sq_trial;
        sq_root <= {sq_root[SqIt-2:0], 1'b0};
      end
    end
  end

  // Overshoot ratio: (excursion << 16) / |amp|, restoring division
  logic [QW-1:0]     rt_q;
  logic [SampleW+1:0] rt_r, rt_d, rt_trial;
  logic [RatCW-1:0]  rt_cnt;
  always_comb rt_trial = {rt_r[SampleW:0], rt_q[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_cnt <= '0;
    end else if (cmd.start_div) begin
      rt_q   <= {max_excursion, 16'd0};
      rt_r   <= '0;
      rt_d   <= amp[SampleW+1] ? -amp : amp;
      rt_cnt <= RatCW'(QW);
    end else if (cmd.ratio_step && rt_cnt != '0) begin
      rt_cnt <= rt_cnt - 1'b1;
      if (rt_trial >= rt_d) begin
        rt_r <= rt_trial - rt_d;
        rt_q <= {rt_q[QW-2:0], 1'b1};
      end else begin
        rt_r <= rt_trial;
        rt_q <= {rt_q[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    status.div_done   = (div_cnt == '0);
    status.sqrt_done  = (sq_cnt == '0);
    status.ratio_done = (rt_cnt == '0);
  end

  // Result capture
  logic [23:0]        ratio_sat;
  logic [1:0]         o_error_next, o_settle_next;
  logic [SampleW-1:0] o_peak_next, o_rms_next, o_final_next;
  logic [TimeW-1:0]   o_duration_next;
  logic               o_ov_valid_next;
  logic [23:0]        o_ratio_next;

  always_comb begin
    if (QW > 24 && (rt_q >> 24) != '0) ratio_sat = 24'hFFFFFF;
    else ratio_sat = 24'(rt_q);
  end

  always_comb begin
    o_error_next = ERR_OK; o_peak_next = '0; o_rms_next = '0; o_final_next = '0;
    o_settle_next = SETTLE_NONE; o_duration_next = '0;
    o_ov_valid_next = 1'b0; o_ratio_next = '0;
    if (order_fault) begin
      o_error_next = ERR_ORDER;
    end else if (!window_open) begin
      o_error_next = ERR_EMPTY;
    end else begin
      o_peak_next  = peak_abs;
      o_rms_next   = sq_root;
      o_final_next = latest_abs;
      if (first_in_band) begin
        o_settle_next = SETTLE_ALREADY;
      end else if (settled_flag) begin
        o_settle_next   = SETTLE_DONE;
        o_duration_next = settled_begin - cfg_event;
      end else if (run_active) begin
        o_settle_next   = SETTLE_DONE;
        o_duration_next = run_begin - cfg_event;
      end
      if (ov_ok) begin
        o_ov_valid_next = 1'b1;
        o_ratio_next    = ratio_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_error    <= o_error_next;
      o_peak     <= o_peak_next;
      o_rms      <= o_rms_next;
      o_final    <= o_final_next;
      o_settle   <= o_settle_next;
      o_duration <= o_duration_next;
      o_ov_valid <= o_ov_valid_next;
      o_ratio    <= o_ratio_next;
    end
  end

endmodule

FILE: design/srm_ctrl.sv
module srm_ctrl
  import srm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_acc,
  input  logic    in_last,
  input  logic    out_acc,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_stall,
  output logic    out_valid
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_ACCUM;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: if (in_acc && in_last) state_next = ST_START;
      ST_START:                        state_next = ST_DIV;
      ST_DIV:   if (status.div_done)   state_next = ST_SQRT;
      ST_SQRT:  if (status.sqrt_done)  state_next = ST_RATIO;
      ST_RATIO: if (status.ratio_done) state_next = ST_OUT;
      ST_OUT:   if (out_acc)           state_next = ST_ACCUM;
      default:                         state_next = ST_ACCUM;
    endcase
  end

  // Per-state commands; input stays stalled from the last request until the result drains
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        in_stall      = 1'b0;
        cmd.take      = in_acc;
      end
      ST_START: cmd.start_div = 1'b1;
      ST_DIV: begin
        cmd.div_step   = 1'b1;
        cmd.ratio_step = 1'b1;
      end
      ST_SQRT: begin
        cmd.sqrt_step  = 1'b1;
        cmd.ratio_step = 1'b1;
      end
      ST_RATIO: begin
        cmd.ratio_step = 1'b1;
        cmd.load_out   = status.ratio_done;
      end
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_acc) |=> state == ST_OUT)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> state == ST_OUT)
    else $error("result not presented after load");

endmodule

FILE: design/step_response_metrics_top.sv
// Step response metrics: settling, peak/RMS/final error, overshoot ratio per window.
// Throughput: one request per cycle while accumulating (ST_ACCUM, non-last samples).
// After the last request: load (START), restoring divider steps (DIV), root steps (SQRT),
//   result capture (RATIO), then result presented (OUT); ratio runs in parallel.
// Input is stalled from the last request until its result is taken.
// Reset (rst, synchronous): config and window registers to 0, window cleared; result outputs are not reset.
module step_response_metrics_top
  import srm_pkg::*;
#(
  parameter int MaxSamples = MAX_WINDOW_SAMPLES,
  parameter int SampleW    = SAMPLE_WIDTH,
  parameter int TimeW      = TIME_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [TimeW-1:0]          cfg_data,
  // input request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TimeW-1:0]          sample_time,
  input  logic signed [SampleW-1:0] reference_value,
  input  logic signed [SampleW-1:0] measured_value,
  input  logic                      last_sample,
  // result request channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                error_code,
  output logic [SampleW-1:0]        peak_error,
  output logic [SampleW-1:0]        rms_error,
  output logic [SampleW-1:0]        final_error,
  output logic [1:0]                settle_status,
  output logic [TimeW-1:0]          settle_duration,
  output logic                      overshoot_valid,
  output logic [23:0]               overshoot_ratio
);

  // Configuration registers
  logic [TimeW-1:0]          event_time, settling_dwell;
  logic [SampleW-1:0]        band_limit;
  logic signed [SampleW-1:0] level_before_step, level_after_step;
  logic                      step_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_time <= '0; band_limit <= '0; settling_dwell <= '0;
      level_before_step <= '0; level_after_step <= '0; step_present <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EVENT_TIME:   event_time        <= cfg_data;
        REG_BAND:         band_limit        <= SampleW'(cfg_data);
        REG_DWELL:        settling_dwell    <= cfg_data;
        REG_LEVEL_BEFORE: level_before_step <= SampleW'(cfg_data);
        REG_LEVEL_AFTER:  level_after_step  <= SampleW'(cfg_data);
        REG_STEP_PRESENT: step_present      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cmd_t    cmd;
  status_t status;
  logic    in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  srm_ctrl u_ctrl (
    .clk, .rst, .in_acc, .in_last(last_sample), .out_acc,
    .status, .cmd, .in_stall, .out_valid
  );

  srm_datapath #(.MaxSamples(MaxSamples), .SampleW(SampleW), .TimeW(TimeW)) u_dp (
    .clk, .rst, .cmd, .status,
    .cfg_event(event_time), .cfg_band(band_limit), .cfg_dwell(settling_dwell),
    .cfg_before(level_before_step), .cfg_after(level_after_step), .cfg_step(step_present),
    .in_time(sample_time), .in_ref(reference_value), .in_meas(measured_value),
    .o_error(error_code), .o_peak(peak_error), .o_rms(rms_error), .o_final(final_error),
    .o_settle(settle_status), .o_duration(settle_duration),
    .o_ov_valid(overshoot_valid), .o_ratio(overshoot_ratio)
  );

endmodule
